// File: src/assert_macros.svh
// assertion macros for the rtl, included by cem_ctl.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: label");

// antecedent implies consequent on the following edge
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

// File: src/cem_pkg.sv
// package for the common element match block: item kinds, walk states,
// and the control bundle from the controller to the cell chain

package cem_pkg;

  localparam int VALUE_W = 32;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_PROBE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } cem_state_t;

  typedef struct packed {
    logic shift;
    logic write;
  } chain_ctl_t;

endpackage

// File: src/cem_cell.sv
// one cell of the reference chain: holds one stored entry
// loads from the input on a write, takes its neighbor's entry on a shift
// depends on cem_pkg

module cem_cell (
  input  logic                             clk,
  input  logic                             write,
  input  logic                             shift,
  input  logic signed [cem_pkg::VALUE_W-1:0] wr_data,
  input  logic signed [cem_pkg::VALUE_W-1:0] neighbor,
  output logic signed [cem_pkg::VALUE_W-1:0] value
);
  import cem_pkg::*;

  always_ff @(posedge clk) begin
    if (shift) begin
      value <= neighbor;
    end else if (write) begin
      value <= wr_data;
    end
  end

endmodule

// File: src/cem_ctl.sv
// controller: list count, probe walk sequencing and the output register
// depends on cem_pkg and assert_macros.svh

`include "assert_macros.svh"

module cem_ctl #(
  parameter int DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          kind,
  input  logic signed [cem_pkg::VALUE_W-1:0]  item_value,
  input  logic signed [cem_pkg::VALUE_W-1:0]  head,
  output cem_pkg::chain_ctl_t                 ctl,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_idx,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [cem_pkg::VALUE_W-1:0]  match_value,
  output logic                                last_of_run
);
  import cem_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL      = CNT_W'(DEPTH);

  cem_state_t state, state_next;

  logic [CNT_W-1:0]            count;
  logic [IDX_W-1:0]            step;
  logic                        hold;
  logic signed [VALUE_W-1:0]   probe;

  logic in_beat;
  logic slot_free;
  logic match_now;
  logic emit_mid;
  logic emit_last;
  logic walk_done;

  assign in_beat   = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign match_now = (CNT_W'(step) < count) && (head == probe);
  assign wr_idx    = count[IDX_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_beat && kind == KIND_PROBE) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (slot_free && step == LAST_STEP) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!hold || slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall  = 1'b1;
    ctl.shift = 1'b0;
    ctl.write = 1'b0;
    emit_mid  = 1'b0;
    emit_last = 1'b0;
    walk_done = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        // input is never stalled here
        ctl.write = in_valid && kind == KIND_LOAD && count < FULL;
      end
      ST_WALK: begin
        ctl.shift = slot_free;
        emit_mid  = slot_free && match_now && hold;
      end
      ST_FLUSH: begin
        emit_last = hold && slot_free;
        walk_done = !hold || slot_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      step      <= '0;
      hold      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_beat && kind == KIND_CLEAR) count <= '0;
      if (ctl.write) count <= count + CNT_W'(1);
      if (in_beat && kind == KIND_PROBE) begin
        step <= '0;
        hold <= 1'b0;
      end
      if (ctl.shift) begin
        step <= step + IDX_W'(1);
        if (match_now) hold <= 1'b1;
      end
      if (walk_done) hold <= 1'b0;
      if (emit_mid || emit_last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_beat && kind == KIND_PROBE) probe <= item_value;
    if (emit_mid || emit_last) begin
      match_value <= probe;
      last_of_run <= emit_last;
    end
  end

  `ASSERT_ALWAYS(a_count_bounded, clk, rst, count <= FULL)
  `ASSERT_ALWAYS(a_idle_no_hold, clk, rst, state != ST_IDLE || !hold)
  `ASSERT_NEXT(a_last_closes_run, clk, rst, emit_last,
               state == ST_IDLE && out_valid && last_of_run)
  `ASSERT_NEXT(a_step_advance, clk, rst, ctl.shift && step != LAST_STEP,
               step == $past(step) + IDX_W'(1))

endmodule

// File: src/common_element_match.sv
// common element match: reference list held in a rotating chain of cells
// input channel: in_valid / in_stall with kind and item_value; output
// channel: out_valid / out_stall with match_value and last_of_run.
// kind clear empties the list, kind load appends one value (ignored once
// DEPTH values are held), kind probe walks the list in stored order and
// gives one beat per equal entry, the final one flagged by last_of_run.
// clear and load produce no beat. a probe rotates the chain through all
// DEPTH cells, one cell per cycle unless out_stall holds it, past a
// single comparator at the head, then a flush state emits the final
// match; no new item is taken until the walk and the flush are done.
// the first result appears once a second match or the end of the walk
// is seen, since the flag needs lookahead.
// while a result waits under out_stall the chain freezes; a finished
// result may wait in the output register while the next item is taken.
// rst (synchronous) empties the list and drops any pending beat; stored
// entries are not cleared. kind 3 is accepted and ignored.
// depends on cem_pkg, cem_cell, cem_ctl

module common_element_match #(
  parameter int DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         kind,
  input  logic signed [cem_pkg::VALUE_W-1:0] item_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [cem_pkg::VALUE_W-1:0] match_value,
  output logic                               last_of_run
);
  import cem_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  chain_ctl_t               ctl;
  logic [IDX_W-1:0]         wr_idx;
  logic signed [VALUE_W-1:0] cells [DEPTH];

  cem_ctl #(
    .DEPTH(DEPTH)
  ) u_ctl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .item_value (item_value),
    .head       (cells[0]),
    .ctl        (ctl),
    .wr_idx     (wr_idx),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .match_value(match_value),
    .last_of_run(last_of_run)
  );

  // ring: each cell takes the next one's entry, the tail takes the head's
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    cem_cell u_cell (
      .clk     (clk),
      .write   (ctl.write && wr_idx == IDX_W'(k)),
      .shift   (ctl.shift),
      .wr_data (item_value),
      .neighbor(cells[(k + 1) % DEPTH]),
      .value   (cells[k])
    );
  end

endmodule
